// ===== hw/rtl/afv_pkg.sv =====
// afv_pkg: shared constants, types and helper functions of the antenna
// integration flag vote block; used by afv_ctrl, afv_dp and the top level
// depends on nothing

package afv_pkg;

  // sizes of the flag table
  localparam int MAX_CHANNELS  = 64;
  localparam int MAX_BASELINES = 64;
  localparam int MAX_POLS      = 4;

  localparam int ROW_W  = MAX_CHANNELS;
  localparam int ADDR_W = $clog2(MAX_BASELINES);
  localparam int CNT_W  = 7;
  localparam int CHAN_W = 6;
  localparam int POL_W  = 4;
  localparam int TAG_W  = 32;
  localparam int FRAC_W = 17;
  localparam int NPOL_W = 3;
  localparam int GRP_N  = ROW_W / 8;
  localparam int SEL_W  = $clog2(GRP_N);

  // stream widths
  localparam int S_DATA_W = 48;
  localparam int M_DATA_W = 40;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASELINES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POLS      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRACTION  = 2'd3;

  // register reset values
  localparam logic [CNT_W-1:0]  CHANNELS_RST  = 7'd64;
  localparam logic [CNT_W-1:0]  BASELINES_RST = 7'd64;
  localparam logic [NPOL_W-1:0] POLS_RST      = 3'd4;
  localparam logic [FRAC_W-1:0] FRACTION_RST  = 17'd39322;

  // item kinds on tuser
  localparam logic MODE_ELEMENT = 1'b0;
  localparam logic MODE_END_BUF = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic              accept;    // latch the input item
    logic              rec_live;  // record the live item, no close needed
    logic              start;     // initialize accumulator and counter
    logic              rd_en;     // read one table row
    logic [ADDR_W-1:0] rd_addr;
    logic              cnt_step;  // add one byte group of the accumulator
    logic [SEL_W-1:0]  cnt_sel;
    logic              finish;    // emit result, clear table, replay held item
  } afv_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic             need_close;
    logic [CNT_W-1:0] eff_nb;
    logic             out_free;
  } afv_status_t;

  // clamp a size register to 1..max
  function automatic logic [CNT_W-1:0] eff_size(logic [CNT_W-1:0] v, int max);
    logic [CNT_W-1:0] r;
    r = v;
    if (v == '0) r = CNT_W'(1);
    if (v > CNT_W'(max)) r = CNT_W'(max);
    return r;
  endfunction

  // ones for channels below the count in use
  function automatic logic [ROW_W-1:0] chan_mask(logic [CNT_W-1:0] nc);
    logic [ROW_W-1:0] m;
    for (int i = 0; i < ROW_W; i++) begin
      m[i] = (CNT_W'(i) < nc);
    end
    return m;
  endfunction

  // ones for polarizations in use
  function automatic logic [POL_W-1:0] pol_mask(logic [NPOL_W-1:0] np);
    logic [POL_W-1:0] m;
    for (int i = 0; i < POL_W; i++) begin
      m[i] = (NPOL_W'(i) < np);
    end
    return m;
  endfunction

  // bit count of one byte
  function automatic logic [3:0] popcount8(logic [7:0] v);
    logic [3:0] s;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + 4'(v[i]);
    end
    return s;
  endfunction

endpackage

// ===== hw/rtl/afv_ram.sv =====
// afv_ram: generic single-write, single-read RAM with registered read data
// depends on nothing

module afv_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/afv_ctrl.sv =====
// afv_ctrl: controller state machine of the flag vote; sequences the
// closing walk over table rows, the channel count and the result load
// depends on afv_pkg

module afv_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  output logic                 s_tready_o,
  input  afv_pkg::afv_status_t status_i,
  output afv_pkg::afv_cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_WALK   = 3'd1;
  localparam logic [2:0] S_DRAIN  = 3'd2;
  localparam logic [2:0] S_COUNT  = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0]                      state_q, state_d;
  logic [afv_pkg::ADDR_W-1:0]      walk_q, walk_d;
  logic [afv_pkg::SEL_W-1:0]       sel_q, sel_d;
  logic                            accept;
  logic                            walk_last;

  assign s_tready_o = (state_q == S_IDLE);
  assign accept     = s_tvalid_i && s_tready_o;
  assign walk_last  = ({1'b0, walk_q} == (status_i.eff_nb - afv_pkg::CNT_W'(1)));

  // next state and commands
  always_comb begin
    state_d = state_q;
    walk_d  = walk_q;
    sel_d   = sel_q;
    cmd_o   = '0;
    cmd_o.rd_addr = walk_q;
    cmd_o.cnt_sel = sel_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.accept = 1'b1;
          if (status_i.need_close) begin
            cmd_o.start = 1'b1;
            walk_d  = '0;
            state_d = S_WALK;
          end else begin
            cmd_o.rec_live = 1'b1;
          end
        end
      end
      S_WALK: begin
        cmd_o.rd_en = 1'b1;
        walk_d = walk_q + afv_pkg::ADDR_W'(1);
        if (walk_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        sel_d   = '0;
        state_d = S_COUNT;
      end
      S_COUNT: begin
        cmd_o.cnt_step = 1'b1;
        sel_d = sel_q + afv_pkg::SEL_W'(1);
        if (sel_q == afv_pkg::SEL_W'(afv_pkg::GRP_N - 1)) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      walk_q  <= '0;
      sel_q   <= '0;
    end else begin
      state_q <= state_d;
      walk_q  <= walk_d;
      sel_q   <= sel_d;
    end
  end

endmodule

// ===== hw/rtl/afv_dp.sv =====
// afv_dp: datapath of the flag vote; configuration registers, time state,
// flag table memory with row valid bits, row accumulator, count and decision
// depends on afv_pkg and afv_ram

module afv_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [afv_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [afv_pkg::FRAC_W-1:0]          cfg_data_i,
  input  logic                                in_mode_i,
  input  logic [afv_pkg::TAG_W-1:0]           in_tag_i,
  input  logic [afv_pkg::CHAN_W-1:0]          in_chan_i,
  input  logic [afv_pkg::POL_W-1:0]           in_pols_i,
  input  logic                                in_eor_i,
  input  logic                                m_tready_i,
  output logic                                m_tvalid_o,
  output logic [afv_pkg::M_DATA_W-1:0]        m_tdata_o,
  input  afv_pkg::afv_cmd_t                   cmd_i,
  output afv_pkg::afv_status_t                status_o
);

  // configuration registers
  logic [afv_pkg::CNT_W-1:0]  chans_q, bases_q;
  logic [afv_pkg::NPOL_W-1:0] pols_q;
  logic [afv_pkg::FRAC_W-1:0] frac_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chans_q <= afv_pkg::CHANNELS_RST;
      bases_q <= afv_pkg::BASELINES_RST;
      pols_q  <= afv_pkg::POLS_RST;
      frac_q  <= afv_pkg::FRACTION_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        afv_pkg::CFG_CHANNELS:  chans_q <= cfg_data_i[afv_pkg::CNT_W-1:0];
        afv_pkg::CFG_BASELINES: bases_q <= cfg_data_i[afv_pkg::CNT_W-1:0];
        afv_pkg::CFG_POLS:      pols_q  <= cfg_data_i[afv_pkg::NPOL_W-1:0];
        afv_pkg::CFG_FRACTION:  frac_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [afv_pkg::CNT_W-1:0] nc, nb;
  assign nc = afv_pkg::eff_size(chans_q, afv_pkg::MAX_CHANNELS);
  assign nb = afv_pkg::eff_size(bases_q, afv_pkg::MAX_BASELINES);

  // time state and table bookkeeping
  logic [afv_pkg::TAG_W-1:0]         cur_q, cur_d;
  logic                              open_q, open_d;
  logic [afv_pkg::CNT_W-1:0]         idx_q, idx_d;
  logic [afv_pkg::ROW_W-1:0]         row_q, row_d;
  logic [afv_pkg::MAX_BASELINES-1:0] valid_q, valid_d;

  // held item, replayed after a close
  logic                       hold_mode_q;
  logic [afv_pkg::TAG_W-1:0]  hold_tag_q;
  logic [afv_pkg::CHAN_W-1:0] hold_chan_q;
  logic [afv_pkg::POL_W-1:0]  hold_pols_q;
  logic                       hold_eor_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      hold_mode_q <= in_mode_i;
      hold_tag_q  <= in_tag_i;
      hold_chan_q <= in_chan_i;
      hold_pols_q <= in_pols_i;
      hold_eor_q  <= in_eor_i;
    end
  end

  assign status_o.need_close = (in_mode_i == afv_pkg::MODE_END_BUF) ? open_q :
                               (open_q && (in_tag_i != cur_q));
  assign status_o.eff_nb     = nb;

  // element record source
  logic                       rec_en;
  logic [afv_pkg::TAG_W-1:0]  rec_tag;
  logic [afv_pkg::CHAN_W-1:0] rec_chan;
  logic [afv_pkg::POL_W-1:0]  rec_pols;
  logic                       rec_eor;

  always_comb begin
    if (cmd_i.finish) begin
      rec_en   = (hold_mode_q == afv_pkg::MODE_ELEMENT);
      rec_tag  = hold_tag_q;
      rec_chan = hold_chan_q;
      rec_pols = hold_pols_q;
      rec_eor  = hold_eor_q;
    end else begin
      rec_en   = cmd_i.rec_live && (in_mode_i == afv_pkg::MODE_ELEMENT);
      rec_tag  = in_tag_i;
      rec_chan = in_chan_i;
      rec_pols = in_pols_i;
      rec_eor  = in_eor_i;
    end
  end

  // bit set for one element, row written through to the table
  logic                      new_time;
  logic [afv_pkg::ROW_W-1:0] base_row, new_row;
  logic [afv_pkg::CNT_W-1:0] base_idx;
  logic                      in_table, hit, wr_en;

  assign new_time = !open_q || (rec_tag != cur_q);
  assign base_row = new_time ? '0 : row_q;
  assign base_idx = new_time ? '0 : idx_q;
  assign in_table = (base_idx < afv_pkg::CNT_W'(afv_pkg::MAX_BASELINES));
  assign hit      = (base_idx < nb) && ({1'b0, rec_chan} < nc) &&
                    ((rec_pols & afv_pkg::pol_mask(pols_q)) != '0);
  assign new_row  = base_row | (hit ? (afv_pkg::ROW_W'(1) << rec_chan) : '0);
  assign wr_en    = rec_en && in_table;

  always_comb begin
    cur_d   = cur_q;
    open_d  = open_q;
    idx_d   = idx_q;
    row_d   = row_q;
    valid_d = valid_q;
    // close empties the table
    if (cmd_i.finish) begin
      valid_d = '0;
      idx_d   = '0;
      row_d   = '0;
      if (hold_mode_q == afv_pkg::MODE_END_BUF) begin
        open_d = 1'b0;
      end
    end
    if (rec_en) begin
      cur_d  = rec_tag;
      open_d = 1'b1;
      row_d  = rec_eor ? '0 : new_row;
      idx_d  = (rec_eor && in_table) ? base_idx + afv_pkg::CNT_W'(1) : base_idx;
      if (wr_en) begin
        valid_d[base_idx[afv_pkg::ADDR_W-1:0]] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q   <= '0;
      open_q  <= 1'b0;
      idx_q   <= '0;
      row_q   <= '0;
      valid_q <= '0;
    end else begin
      cur_q   <= cur_d;
      open_q  <= open_d;
      idx_q   <= idx_d;
      row_q   <= row_d;
      valid_q <= valid_d;
    end
  end

  // flag table
  logic [afv_pkg::ROW_W-1:0] rdata;

  afv_ram #(
    .WIDTH (afv_pkg::ROW_W),
    .DEPTH (afv_pkg::MAX_BASELINES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (base_idx[afv_pkg::ADDR_W-1:0]),
    .wdata_i (new_row),
    .re_i    (cmd_i.rd_en),
    .raddr_i (cmd_i.rd_addr),
    .rdata_o (rdata)
  );

  // and of all rows in use, rows never written read as zero
  logic                      rd_vld_q, rowv_q;
  logic [afv_pkg::ROW_W-1:0] acc_q;
  logic [afv_pkg::CNT_W-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    rowv_q <= valid_q[cmd_i.rd_addr];
    if (cmd_i.start) begin
      acc_q <= afv_pkg::chan_mask(nc);
    end else if (rd_vld_q) begin
      acc_q <= acc_q & (rowv_q ? rdata : '0);
    end
  end

  // channel count, one byte group a cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_step) begin
      cnt_q <= cnt_q + afv_pkg::CNT_W'(afv_pkg::popcount8(acc_q[cmd_i.cnt_sel*8 +: 8]));
    end
  end

  // decision: count / channels against the fraction threshold
  logic [23:0] thr, lhs;
  logic        flag;

  assign thr  = 24'(frac_q) * 24'(nc);
  assign lhs  = 24'({cnt_q, 16'h0000});
  assign flag = (nc == afv_pkg::CNT_W'(1)) ? (cnt_q == afv_pkg::CNT_W'(1)) : (lhs > thr);

  // output register
  logic                         m_valid_q;
  logic [afv_pkg::M_DATA_W-1:0] m_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      m_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      m_data_q <= {cnt_q, flag, cur_q};
    end
  end

  assign status_o.out_free = !m_valid_q || m_tready_i;
  assign m_tvalid_o        = m_valid_q;
  assign m_tdata_o         = m_data_q;

endmodule

// ===== hw/rtl/antenna_integration_flag_vote.sv =====
// antenna_integration_flag_vote: top level of the flag vote block
// depends on afv_pkg, afv_ctrl, afv_dp (and afv_ram below it)
//
// Usage: flag elements enter on the s_axis channel, one channel of one
// baseline row per item; tlast marks the last element of a row and tuser
// set to one marks an end-of-buffer item. The m_axis channel carries one
// decision item for each closed integration time. Sizes and the threshold
// are written through the cfg port while the block is idle.
// An element that does not close a time is recorded as it is accepted, and
// the block stays ready for the next item. An item that closes a time is
// accepted, then the B baselines in use are walked over the table rows
// through the single read port, a drain state follows, the channels are
// counted a byte at a time and the result is loaded.
// The output register lets a new item enter while a result waits; a stalled
// receiver holds the block only when the next result is ready to load.
// Reset: no time is open, the table is empty, registers take their defaults.

module antenna_integration_flag_vote (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [afv_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [afv_pkg::FRAC_W-1:0]          cfg_data_i,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // time_tag[31:0], channel[37:32], pol_flags[41:38], zero fill
  input  logic [afv_pkg::S_DATA_W-1:0]        s_axis_tdata_i,
  // mode
  input  logic                                s_axis_tuser_i,
  // end_of_row
  input  logic                                s_axis_tlast_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // closed_time[31:0], flag_time[32], flagged_channels[39:33]
  output logic [afv_pkg::M_DATA_W-1:0]        m_axis_tdata_o
);

  afv_pkg::afv_cmd_t    cmd;
  afv_pkg::afv_status_t status;

  afv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  afv_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_mode_i  (s_axis_tuser_i),
    .in_tag_i   (s_axis_tdata_i[31:0]),
    .in_chan_i  (s_axis_tdata_i[37:32]),
    .in_pols_i  (s_axis_tdata_i[41:38]),
    .in_eor_i   (s_axis_tlast_i),
    .m_tready_i (m_axis_tready_i),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tdata_o  (m_axis_tdata_o),
    .cmd_i      (cmd),
    .status_o   (status)
  );

endmodule

// ===== hw/rtl/afv_chk.sv =====
// afv_chk: port-level checks of the flag vote, bound to the top level
// depends on antenna_integration_flag_vote ports only

module afv_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [39:0] m_axis_tdata_o
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // the count never exceeds the channel maximum
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[39:33] <= 7'd64))
    else $error("flagged channel count out of range");

  // a flag decision needs at least one fully flagged channel
  a_flag_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[32]) |-> (m_axis_tdata_o[39:33] != 7'd0))
    else $error("flag set with no flagged channel");

  // a new result is loaded only at the end of a close, with input closed
  a_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(!s_axis_tready_o))
    else $error("result appeared while input was open");

endmodule

bind antenna_integration_flag_vote afv_chk u_afv_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
